>>> sv/slx_pkg.sv
package slx_pkg;

  // text geometry
  localparam int MAX_TEXT  = 4096;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 12;
  localparam int POS_MAX_I = ((MAX_TEXT - 1) < 4095) ? (MAX_TEXT - 1) : 4095;
  localparam logic [POS_W-1:0] POS_MAX = POS_MAX_I[POS_W-1:0];
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // word buffer
  localparam int BUF_DEPTH = 12;
  localparam int BUF_IDX_W = 4;
  localparam int FNAME_DOT = 8;

  // lexer modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_WORD   = 3'd1;
  localparam logic [2:0] MODE_DOLLAR = 3'd2;
  localparam logic [2:0] MODE_VAR    = 3'd3;
  localparam logic [2:0] MODE_DEAD   = 3'd4;

  // token kinds
  localparam logic [4:0] KIND_LS       = 5'd0;
  localparam logic [4:0] KIND_FILENAME = 5'd7;
  localparam logic [4:0] KIND_FOLDER   = 5'd8;
  localparam logic [4:0] KIND_VARIABLE = 5'd9;
  localparam logic [4:0] KIND_SLASH    = 5'd10;
  localparam logic [4:0] KIND_ASSIGN   = 5'd11;
  localparam logic [4:0] KIND_PLUS     = 5'd12;
  localparam logic [4:0] KIND_MINUS    = 5'd13;
  localparam logic [4:0] KIND_STAR     = 5'd14;
  localparam logic [4:0] KIND_LPAREN   = 5'd15;
  localparam logic [4:0] KIND_RPAREN   = 5'd16;
  localparam logic [4:0] KIND_END      = 5'd17;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_83     = 3'd1;
  localparam logic [2:0] ERR_FOLDER_LEN = 3'd2;
  localparam logic [2:0] ERR_DOLLAR     = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

  // keyword table, index equals token kind
  localparam int KW_NUM    = 7;
  localparam int KW_MAXLEN = 5;
  localparam logic [7:0] KW_CHARS [KW_NUM][KW_MAXLEN] = '{
    '{"l", "s", 8'h00, 8'h00, 8'h00},
    '{"c", "d", 8'h00, 8'h00, 8'h00},
    '{"c", "a", "t", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t"},
    '{"e", "x", "e", "c", 8'h00},
    '{"s", "e", "t", 8'h00, 8'h00},
    '{"e", "c", "h", "o", 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd2, 3'd3, 3'd5, 3'd4, 3'd3, 3'd4};

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [4:0]       kind;
    logic [2:0]       err;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [7:0]       bad;
  } res_t;

  // everything one input item causes: one or two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } pair_t;

  typedef struct packed {
    logic [7:0] sep;
    logic [3:0] limit;
  } cfg_t;

endpackage

>>> sv/slx_if.sv
interface lex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface lex_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [2:0]  error_code;
  logic [11:0] start_pos;
  logic [11:0] token_len;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, output token_kind, output error_code, output start_pos,
                  output token_len, output bad_char, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input start_pos,
                input token_len, input bad_char, input last_of_run, output ready);
endinterface

>>> sv/slx_front.sv
module slx_front
  import slx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  lex_in_if.sink   in_i,
  input  cfg_t     cfg_i,
  input  logic     q_ready_i,
  output logic     push_o,
  output pair_t    pair_o
);

  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_DOLLAR = "$";

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c inside {[8'd9:8'd13], 8'd32});
  endfunction

  function automatic res_t mk_res(logic [4:0] kind, logic [2:0] err,
                                  logic [POS_W-1:0] start, logic [LEN_W-1:0] len,
                                  logic [7:0] bad);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.bad   = bad;
    return r;
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             dot_q, dot_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] cpos_q, cpos_d;
  logic [7:0]       buf_q [BUF_DEPTH];

  logic                 wr_en;
  logic [BUF_IDX_W-1:0] wr_idx;
  logic                 in_fire;
  logic [7:0]           c;
  logic [POS_W-1:0]     pos_inc;
  logic [LEN_W-1:0]     cnt_inc;

  logic       kw_hit, kw_match, fname_ok;
  logic [4:0] kw_kind;
  res_t       word_res;
  logic       word_bad;

  logic cls_v, new_v, fall, bad;
  res_t cls_r, new_r;

  assign in_i.ready = q_ready_i;
  assign in_fire    = in_i.valid && q_ready_i;
  assign c          = in_i.ch;
  assign pos_inc    = (cpos_q < POS_MAX) ? cpos_q + 1'b1 : cpos_q;
  assign cnt_inc    = (cnt_q < LEN_MAX) ? cnt_q + 1'b1 : cnt_q;

  // classify the word held in the buffer
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_LS;
    for (int k = 0; k < KW_NUM; k++) begin
      kw_match = (cnt_q == LEN_W'(KW_LEN[k]));
      for (int j = 0; j < KW_MAXLEN; j++) begin
        if (j < int'(KW_LEN[k])) begin
          kw_match = kw_match && (buf_q[j] == KW_CHARS[k][j]);
        end
      end
      if (kw_match && !kw_hit) begin
        kw_hit  = 1'b1;
        kw_kind = 5'(k);
      end
    end

    fname_ok = (cnt_q == LEN_W'(BUF_DEPTH));
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (i == FNAME_DOT) begin
        fname_ok = fname_ok && (buf_q[i] == CH_DOT);
      end else begin
        fname_ok = fname_ok && is_alpha(buf_q[i]);
      end
    end

    word_bad = 1'b0;
    if (kw_hit) begin
      word_res = mk_res(kw_kind, ERR_NONE, start_q, cnt_q, 8'h00);
    end else if (fname_ok) begin
      word_res = mk_res(KIND_FILENAME, ERR_NONE, start_q, cnt_q, 8'h00);
    end else if (dot_q) begin
      word_res = mk_res(KIND_LS, ERR_BAD_83, start_q, cnt_q, 8'h00);
      word_bad = 1'b1;
    end else if (cnt_q <= LEN_W'(cfg_i.limit)) begin
      word_res = mk_res(KIND_FOLDER, ERR_NONE, start_q, cnt_q, 8'h00);
    end else begin
      word_res = mk_res(KIND_LS, ERR_FOLDER_LEN, start_q, cnt_q, 8'h00);
      word_bad = 1'b1;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    dot_d   = dot_q;
    start_d = start_q;
    cpos_d  = cpos_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q[BUF_IDX_W-1:0];
    cls_v   = 1'b0;
    cls_r   = word_res;
    new_v   = 1'b0;
    new_r   = mk_res(KIND_END, ERR_NONE, cpos_q, '0, 8'h00);
    fall    = 1'b0;
    bad     = 1'b0;

    if (in_fire) begin
      if (mode_q == MODE_DEAD) begin
        if (in_i.end_of_text) begin
          mode_d  = MODE_IDLE;
          cnt_d   = '0;
          dot_d   = 1'b0;
          start_d = '0;
          cpos_d  = '0;
        end else begin
          cpos_d = pos_inc;
        end
      end else if (in_i.end_of_text) begin
        case (mode_q)
          MODE_WORD: begin
            cls_v = 1'b1;
            bad   = word_bad;
          end
          MODE_DOLLAR: begin
            cls_v = 1'b1;
            cls_r = mk_res(KIND_LS, ERR_DOLLAR, start_q, LEN_W'(1), 8'h00);
            bad   = 1'b1;
          end
          MODE_VAR: begin
            cls_v = 1'b1;
            cls_r = mk_res(KIND_VARIABLE, ERR_NONE, start_q, cnt_q, 8'h00);
          end
          default: ;
        endcase
        new_v   = !bad;
        mode_d  = MODE_IDLE;
        cnt_d   = '0;
        dot_d   = 1'b0;
        start_d = '0;
        cpos_d  = '0;
      end else begin
        cpos_d = pos_inc;
        case (mode_q)
          MODE_WORD: begin
            if (is_alpha(c) || c == CH_DOT) begin
              wr_en = (cnt_q < LEN_W'(BUF_DEPTH));
              cnt_d = cnt_inc;
              if (c == CH_DOT) begin
                dot_d = 1'b1;
              end
            end else begin
              cls_v = 1'b1;
              if (word_bad) begin
                mode_d = MODE_DEAD;
              end else begin
                fall = 1'b1;
              end
            end
          end
          MODE_DOLLAR: begin
            if (is_alpha(c)) begin
              mode_d = MODE_VAR;
              cnt_d  = LEN_W'(2);
            end else begin
              cls_v  = 1'b1;
              cls_r  = mk_res(KIND_LS, ERR_DOLLAR, start_q, LEN_W'(1), 8'h00);
              mode_d = MODE_DEAD;
            end
          end
          MODE_VAR: begin
            if (is_alpha(c) || is_digit(c)) begin
              cnt_d = cnt_inc;
            end else begin
              cls_v = 1'b1;
              cls_r = mk_res(KIND_VARIABLE, ERR_NONE, start_q, cnt_q, 8'h00);
              fall  = 1'b1;
            end
          end
          default: fall = 1'b1;
        endcase

        // the character starts something new
        if (fall) begin
          mode_d = MODE_IDLE;
          new_r  = mk_res(KIND_SLASH, ERR_NONE, cpos_q, LEN_W'(1), 8'h00);
          if (is_space(c)) begin
            new_v = 1'b0;
          end else if (c == cfg_i.sep) begin
            new_v = 1'b1;
          end else if (c == CH_EQ) begin
            new_v      = 1'b1;
            new_r.kind = KIND_ASSIGN;
          end else if (c == CH_PLUS) begin
            new_v      = 1'b1;
            new_r.kind = KIND_PLUS;
          end else if (c == CH_MINUS) begin
            new_v      = 1'b1;
            new_r.kind = KIND_MINUS;
          end else if (c == CH_STAR) begin
            new_v      = 1'b1;
            new_r.kind = KIND_STAR;
          end else if (c == CH_LPAREN) begin
            new_v      = 1'b1;
            new_r.kind = KIND_LPAREN;
          end else if (c == CH_RPAREN) begin
            new_v      = 1'b1;
            new_r.kind = KIND_RPAREN;
          end else if (c == CH_DOLLAR) begin
            mode_d  = MODE_DOLLAR;
            start_d = cpos_q;
            cnt_d   = LEN_W'(1);
          end else if (is_alpha(c)) begin
            mode_d  = MODE_WORD;
            start_d = cpos_q;
            wr_en   = 1'b1;
            wr_idx  = '0;
            cnt_d   = LEN_W'(1);
            dot_d   = 1'b0;
          end else begin
            new_v  = 1'b1;
            new_r  = mk_res(KIND_LS, ERR_UNEXPECTED, cpos_q, LEN_W'(1), c);
            mode_d = MODE_DEAD;
          end
        end
      end
    end

    if (cls_v) begin
      pair_o.r0  = cls_r;
      pair_o.r1  = new_r;
      pair_o.two = new_v;
      push_o     = 1'b1;
    end else begin
      pair_o.r0  = new_r;
      pair_o.r1  = new_r;
      pair_o.two = 1'b0;
      push_o     = new_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      dot_q   <= 1'b0;
      start_q <= '0;
      cpos_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      dot_q   <= dot_d;
      start_q <= start_d;
      cpos_q  <= cpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_idx] <= c;
    end
  end

endmodule

>>> sv/slx_queue.sv
module slx_queue
  import slx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  pair_t push_data_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  avail_o,
  output pair_t head_o
);

  pair_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/slx_back.sv
module slx_back
  import slx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  pair_t      head_i,
  output logic       pop_o,
  lex_out_if.source  out_o
);

  logic  valid_q;
  logic  idx_q;
  pair_t pair_q;
  logic  last;
  logic  fire;
  res_t  cur;

  assign last  = !pair_q.two || idx_q;
  assign fire  = valid_q && out_o.ready;
  assign pop_o = avail_i && (!valid_q || (fire && last));
  assign cur   = idx_q ? pair_q.r1 : pair_q.r0;

  assign out_o.valid       = valid_q;
  assign out_o.token_kind  = cur.kind;
  assign out_o.error_code  = cur.err;
  assign out_o.start_pos   = cur.start;
  assign out_o.token_len   = cur.len;
  assign out_o.bad_char    = cur.bad;
  assign out_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (fire) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= 1'b0;
      end else begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pair_q <= head_i;
    end
  end

endmodule

>>> sv/shell_command_lexer.sv
// a result passes through the result queue and the output register before it is offered
// throughput: one character per cycle; an item with two results hands them out in two output transfers
// the front lexer stalls only when its four-entry result queue is full
// reset: rst_ni is asynchronous, active low; it clears the lexer to idle at position 0,
// empties the queue and the output stage, and loads separator '/' and folder limit 8
module shell_command_lexer
  import slx_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  lex_in_if.sink       in_i,
  lex_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // register selects, one word apart
  localparam logic REG_SEP   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  cfg_t  cfg_q;
  logic  cfg_wr;

  logic  push;
  pair_t push_pair;
  logic  q_ready;
  logic  q_avail;
  logic  pop;
  pair_t head;

  // configuration port: no wait states, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep   <= 8'd47;
      cfg_q.limit <= 4'd8;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SEP:   cfg_q.sep   <= pwdata[7:0];
        REG_LIMIT: cfg_q.limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // readback of the selected register, zero extended
  always_comb begin
    case (paddr[2])
      REG_SEP:   prdata = {24'h0, cfg_q.sep};
      REG_LIMIT: prdata = {28'h0, cfg_q.limit};
      default:   prdata = '0;
    endcase
  end

  // front: takes characters, tracks the word and emits the results of each transfer
  slx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_q),
    .q_ready_i (q_ready),
    .push_o    (push),
    .pair_o    (push_pair)
  );

  // short queue of result groups so the two sides stall independently
  slx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pair),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .avail_o     (q_avail),
    .head_o      (head)
  );

  // back: output register that hands out one result per transfer
  slx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> sv/slx_checker.sv
module slx_checker
  import slx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_kind,
  input logic [2:0]  error_code,
  input logic [11:0] token_len,
  input logic [7:0]  bad_char,
  input logic        last_of_run
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(error_code)
      && $stable(token_len) && $stable(bad_char) && $stable(last_of_run))
    else $error("stalled result changed");

  // an error ends the run of its item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && error_code != ERR_NONE |-> last_of_run && token_kind == KIND_LS)
    else $error("error result not final");

  // end token is empty and final
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && token_kind == KIND_END |-> token_len == '0 && last_of_run
      && error_code == ERR_NONE)
    else $error("bad end token");

  // only the unexpected character error carries a character
  a_bad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && bad_char != 8'h00 |-> error_code == ERR_UNEXPECTED)
    else $error("stray bad character");

endmodule

bind shell_command_lexer slx_checker u_slx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .token_kind  (out_o.token_kind),
  .error_code  (out_o.error_code),
  .token_len   (out_o.token_len),
  .bad_char    (out_o.bad_char),
  .last_of_run (out_o.last_of_run)
);

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slx_pkg::*;

  // register map: byte addresses on the config port
  localparam logic [2:0] REG_SEPARATOR    = 3'd0;
  localparam logic [2:0] REG_FOLDER_LIMIT = 3'd4;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PHASES        = 9;
  localparam int IDLE_PERCENT  = 12;
  localparam int LONG_RUN      = 20;

  typedef struct {
    bit [4:0]  kind;
    bit [2:0]  err;
    bit [11:0] start;
    bit [11:0] len;
    bit [7:0]  bad;
    bit        last;
  } lex_token_t;

  // mirrors the lexer state and keeps the queue of tokens still owed by the block
  class token_scoreboard;
    bit [7:0]   sep_char;
    bit [3:0]   folder_limit;
    bit [2:0]   mode;
    bit [7:0]   word_buf [BUF_DEPTH];
    bit [11:0]  word_len;
    bit         dot_seen;
    bit [11:0]  token_start;
    bit [11:0]  char_pos;
    lex_token_t expected_tokens [$];
    string      keywords [KW_NUM];
    int         failures;
    int         tokens_checked;
    int         texts_done;
    int         kinds_seen [18];
    int         errors_seen [5];

    function new();
      keywords     = '{"ls", "cd", "cat", "print", "exec", "set", "echo"};
      sep_char     = 8'd47;
      folder_limit = 4'd8;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
      restart();
    endfunction

    function void restart();
      mode        = MODE_IDLE;
      word_len    = '0;
      dot_seen    = 1'b0;
      token_start = '0;
      char_pos    = '0;
    endfunction

    function void write_register(logic [2:0] addr, logic [31:0] data);
      if (addr == REG_SEPARATOR) sep_char = data[7:0];
      else if (addr == REG_FOLDER_LIMIT) folder_limit = data[3:0];
    endfunction

    function bit is_letter(bit [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_digit(bit [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void expect_token(bit [4:0] kind, bit [2:0] err, bit [11:0] start,
                               bit [11:0] len, bit [7:0] bad);
      lex_token_t t;
      t.kind  = kind;
      t.err   = err;
      t.start = start;
      t.len   = len;
      t.bad   = bad;
      t.last  = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // flag the final token caused by one item
    function void seal(int n);
      if (n > 0) expected_tokens[expected_tokens.size()-1].last = 1'b1;
    endfunction

    function bit matches_keyword(int k);
      string w;
      w = keywords[k];
      if (word_len != w.len()) return 1'b0;
      for (int j = 0; j < w.len(); j++)
        if (word_buf[j] != w[j]) return 1'b0;
      return 1'b1;
    endfunction

    function bit is_83_name();
      if (word_len != 12) return 1'b0;
      for (int j = 0; j < 12; j++) begin
        if (j == FNAME_DOT) begin
          if (word_buf[j] != ".") return 1'b0;
        end else if (!is_letter(word_buf[j])) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // returns 1 when the closed word is a lexing error
    function bit close_word();
      for (int k = 0; k < KW_NUM; k++) begin
        if (matches_keyword(k)) begin
          expect_token(5'(KIND_LS + k), ERR_NONE, token_start, word_len, 8'h00);
          return 1'b0;
        end
      end
      if (is_83_name()) begin
        expect_token(KIND_FILENAME, ERR_NONE, token_start, word_len, 8'h00);
        return 1'b0;
      end
      if (dot_seen) begin
        expect_token(KIND_LS, ERR_BAD_83, token_start, word_len, 8'h00);
        return 1'b1;
      end
      if (word_len <= folder_limit) begin
        expect_token(KIND_FOLDER, ERR_NONE, token_start, word_len, 8'h00);
        return 1'b0;
      end
      expect_token(KIND_LS, ERR_FOLDER_LEN, token_start, word_len, 8'h00);
      return 1'b1;
    endfunction

    // returns 0 for an item that the lexer drops after an error
    function bit note_input(bit [7:0] c, bit eot);
      bit [11:0] pos;
      int        n;
      bit        failed;
      pos    = char_pos;
      n      = 0;
      failed = 1'b0;
      if (mode == MODE_DEAD) begin
        if (eot) begin
          restart();
          texts_done++;
        end else if (char_pos < POS_MAX) begin
          char_pos++;
        end
        return 1'b0;
      end
      if (eot) begin
        case (mode)
          MODE_WORD: begin
            failed = close_word();
            n++;
          end
          MODE_DOLLAR: begin
            expect_token(KIND_LS, ERR_DOLLAR, token_start, 12'd1, 8'h00);
            n++;
            failed = 1'b1;
          end
          MODE_VAR: begin
            expect_token(KIND_VARIABLE, ERR_NONE, token_start, word_len, 8'h00);
            n++;
          end
          default: begin
          end
        endcase
        // an error on the end item replaces END
        if (!failed) begin
          expect_token(KIND_END, ERR_NONE, pos, 12'd0, 8'h00);
          n++;
        end
        restart();
        texts_done++;
        seal(n);
        return 1'b1;
      end

      if (char_pos < POS_MAX) char_pos++;

      case (mode)
        MODE_WORD: begin
          if (is_letter(c) || c == ".") begin
            if (word_len < BUF_DEPTH) word_buf[word_len] = c;
            if (word_len < LEN_MAX) word_len++;
            if (c == ".") dot_seen = 1'b1;
            return 1'b1;
          end
          // a bad word swallows the character that closed it
          if (close_word()) begin
            mode = MODE_DEAD;
            seal(1);
            return 1'b1;
          end
          n++;
          mode = MODE_IDLE;
        end
        MODE_DOLLAR: begin
          if (is_letter(c)) begin
            mode     = MODE_VAR;
            word_len = 12'd2;
            return 1'b1;
          end
          expect_token(KIND_LS, ERR_DOLLAR, token_start, 12'd1, 8'h00);
          mode = MODE_DEAD;
          seal(1);
          return 1'b1;
        end
        MODE_VAR: begin
          if (is_letter(c) || is_digit(c)) begin
            if (word_len < LEN_MAX) word_len++;
            return 1'b1;
          end
          expect_token(KIND_VARIABLE, ERR_NONE, token_start, word_len, 8'h00);
          n++;
          mode = MODE_IDLE;
        end
        default: begin
        end
      endcase

      // between tokens: whitespace beats the separator, which beats the fixed operators
      if (!is_blank(c)) begin
        if (c == sep_char) begin
          expect_token(KIND_SLASH, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "=") begin
          expect_token(KIND_ASSIGN, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "+") begin
          expect_token(KIND_PLUS, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "-") begin
          expect_token(KIND_MINUS, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "*") begin
          expect_token(KIND_STAR, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "(") begin
          expect_token(KIND_LPAREN, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == ")") begin
          expect_token(KIND_RPAREN, ERR_NONE, pos, 12'd1, 8'h00);
          n++;
        end else if (c == "$") begin
          mode        = MODE_DOLLAR;
          token_start = pos;
          word_len    = 12'd1;
        end else if (is_letter(c)) begin
          mode        = MODE_WORD;
          token_start = pos;
          word_buf[0] = c;
          word_len    = 12'd1;
          dot_seen    = 1'b0;
        end else begin
          expect_token(KIND_LS, ERR_UNEXPECTED, pos, 12'd1, c);
          n++;
          mode = MODE_DEAD;
        end
      end
      seal(n);
      return 1'b1;
    endfunction

    function void check_result(lex_token_t got);
      lex_token_t want;
      if (expected_tokens.size() == 0) begin
        $error("spurious result: kind %0d, error %0d, start %0d, len %0d",
               got.kind, got.err, got.start, got.len);
        failures++;
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (want.err == ERR_NONE) kinds_seen[want.kind]++;
      else errors_seen[want.err]++;
      if (got.kind != want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.err != want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, got.err);
        failures++;
      end
      if (got.start != want.start) begin
        $error("start_pos: expected %0d, got %0d", want.start, got.start);
        failures++;
      end
      if (got.len != want.len) begin
        $error("token_len: expected %0d, got %0d", want.len, got.len);
        failures++;
      end
      if (got.bad != want.bad) begin
        $error("bad_char: expected %0d, got %0d", want.bad, got.bad);
        failures++;
      end
      if (got.last != want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lex_in_if  char_chan ();
  lex_out_if token_chan ();

  shell_command_lexer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_chan),
    .out_o   (token_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  token_scoreboard sb = new();

  // calm switches off idling on both sides for a stretch
  bit         calm;
  int         live_items;
  int         settings_used;
  bit [7:0]   text_buf [$];

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // sink side: ready changes on the falling edge, mostly high
  initial begin
    token_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      token_chan.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // every token transfer is checked against the oldest prediction
  initial begin : token_monitor
    lex_token_t got;
    forever begin
      @(posedge clk_i);
      if (token_chan.valid && token_chan.ready) begin
        got.kind  = token_chan.token_kind;
        got.err   = token_chan.error_code;
        got.start = token_chan.start_pos;
        got.len   = token_chan.token_len;
        got.bad   = token_chan.bad_char;
        got.last  = token_chan.last_of_run;
        sb.check_result(got);
      end
    end
  end

  // entered and left at a falling edge; the transfer is noted at the rising edge
  task automatic send_item(input bit [7:0] c, input bit eot);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      char_chan.valid = 1'b0;
      char_chan.ch    = 8'($urandom);
      @(negedge clk_i);
    end
    char_chan.valid       = 1'b1;
    char_chan.ch          = c;
    char_chan.end_of_text = eot;
    do @(posedge clk_i); while (!char_chan.ready);
    if (sb.note_input(c, eot)) live_items++;
    @(negedge clk_i);
  endtask

  // sends the text buffer followed by the end item, ch is don't-care there
  task automatic send_text();
    foreach (text_buf[i]) send_item(text_buf[i], 1'b0);
    send_item(8'($urandom), 1'b1);
    text_buf.delete();
  endtask

  task automatic add_char(input bit [7:0] ch);
    text_buf.insert(text_buf.size(), ch);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_string(input string s);
    add_string(s);
    send_text();
  endtask

  task automatic add_letters(input int n);
    for (int i = 0; i < n; i++)
      add_char($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7a))
                                 : 8'($urandom_range(8'h41, 8'h5a)));
  endtask

  task automatic add_operator();
    case ($urandom_range(6))
      0: add_char(sb.sep_char);
      1: add_char("=");
      2: add_char("+");
      3: add_char("-");
      4: add_char("*");
      5: add_char("(");
      default: add_char(")");
    endcase
  endtask

  task automatic add_blanks();
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++)
      add_char($urandom_range(3) == 0 ? 8'($urandom_range(9, 13)) : 8'h20);
  endtask

  // mostly well-formed commands with random content, with noise and broken tokens mixed in
  task automatic build_random_text();
    int ntok;
    int pick;
    int n;
    string kw;
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        kw = sb.keywords[$urandom_range(KW_NUM - 1)];
        // now and then a wrong case or an extra letter turns it into a folder or a length error
        if ($urandom_range(9) == 0) kw = kw.toupper();
        add_string(kw);
        if ($urandom_range(9) == 0) add_letters(1);
      end else if (pick < 35) begin
        add_letters(8);
        add_char(".");
        add_letters($urandom_range(9) == 0 ? $urandom_range(2, 4) : 3);
      end else if (pick < 55) begin
        if (sb.folder_limit == 0 || $urandom_range(9) == 0) n = $urandom_range(1, 14);
        else n = $urandom_range(1, sb.folder_limit);
        add_letters(n);
      end else if (pick < 68) begin
        add_char("$");
        add_letters(1);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
          if ($urandom_range(1)) add_char(8'($urandom_range(8'h30, 8'h39)));
          else add_letters(1);
      end else if (pick < 88) begin
        add_operator();
      end else if (pick < 94) begin
        add_char(8'($urandom_range(255)));
      end else if (pick < 97) begin
        // dollar with no letter after it
        add_char("$");
        if ($urandom_range(1)) add_char(8'($urandom_range(8'h30, 8'h39)));
      end else begin
        // dotted word that is no 8.3 name
        add_letters($urandom_range(1, 6));
        add_char(".");
        add_letters($urandom_range(0, 4));
      end
      // let the end item close the last word about half the time
      if (t < ntok - 1 || $urandom_range(1)) begin
        if ($urandom_range(9) < 7) add_blanks();
        else add_operator();
      end
    end
  endtask

  task automatic reg_access(input bit write, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write) sb.write_register(addr, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // only called with the lexer idle: no transfer in flight, no result owed
  task automatic configure(input bit [7:0] sep, input bit [3:0] limit);
    logic [31:0] rd;
    reg_access(1'b1, REG_SEPARATOR, {24'h0, sep}, rd);
    reg_access(1'b1, REG_FOLDER_LIMIT, {28'h0, limit}, rd);
    reg_access(1'b0, REG_SEPARATOR, 32'h0, rd);
    if (rd[7:0] !== sep) begin
      $error("separator_char readback: expected %0d, got %0d", sep, rd[7:0]);
      sb.failures++;
    end
    reg_access(1'b0, REG_FOLDER_LIMIT, 32'h0, rd);
    if (rd[3:0] !== limit) begin
      $error("folder_len_limit readback: expected %0d, got %0d", limit, rd[3:0]);
      sb.failures++;
    end
    settings_used++;
  endtask

  // drop valid, then wait out every owed token and the pipeline behind it
  task automatic drain();
    char_chan.valid = 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // run limit, far above the slowest legal run
  initial begin
    #(20_000_000);
    $display("shell_command_lexer verification failed");
    $finish;
  end

  initial begin : stimulus
    int sep_list [PHASES];
    int lim_list [PHASES];
    int phase_goal;
    sep_list = '{47, 0, 255, "a", "=", " ", ".", 92, 47};
    lim_list = '{12, 1, 12, 5, 8, 3, 0, 15, 8};

    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    char_chan.valid       = 1'b0;
    char_chan.ch          = '0;
    char_chan.end_of_text = 1'b0;
    calm                  = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed texts under the reset settings: separator '/', folder limit 8
    send_string("ls cd cat print exec set echo");
    send_string("");
    send_string("abcdefgh.ijk/ABCDEFGH.IJK");
    send_string("=+-*() /");
    text_buf = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    send_string("cd");
    send_string("$a1Z9 $b");
    send_string("$");
    send_string("$1 ls");
    // bad word closed by an operator: the operator and the rest are dropped
    send_string("abc.d+ls ");
    send_string("ab.c");
    send_string("abcdefgh ABCDEFGHI");
    send_string("LS Echo lsx abcdefgh.ij abcdefghijk.");
    send_string("cat #x");
    text_buf = '{"a", 8'h00};
    send_text();
    text_buf = '{8'hff};
    send_text();

    // a word longer than the buffer and a long variable, no idling
    calm = 1'b1;
    repeat (LONG_RUN) add_char("a");
    send_text();
    add_string("$a");
    repeat (LONG_RUN) add_char("7");
    send_string(" ");
    calm = 1'b0;
    drain();

    // random commands under a run of register settings
    phase_goal = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      configure(8'(sep_list[p]), 4'(lim_list[p]));
      calm       = (p == 3);
      live_items = 0;
      while (live_items < phase_goal) begin
        build_random_text();
        send_text();
      end
      drain();
    end
    calm = 1'b0;

    $display("lexed %0d texts into %0d results over %0d register settings",
             sb.texts_done, sb.tokens_checked, settings_used);
    $display("token kinds hit: %0d of 18, error codes hit: %0d of 4",
             sb.kinds_seen.sum() with (int'(item != 0)),
             sb.errors_seen.sum() with (int'(item != 0)));
    if (sb.failures == 0) begin
      $display("shell_command_lexer verification clean");
    end else begin
      $display("shell_command_lexer verification failed");
    end
    $finish;
  end

endmodule
